[rtl/apuc_pkg.sv]
// types, constants and conversion functions for the audio pcm / mu-law codec
package apuc_pkg;

   typedef enum logic [1:0] {
      MODE_ULAW  = 2'd0,
      MODE_PCM8  = 2'd1,
      MODE_PCM16 = 2'd2
   } codec_mode_type;

   typedef enum logic {
      KIND_DECODE = 1'b0,
      KIND_ENCODE = 1'b1
   } item_kind_type;

   localparam logic [7:0]  ULAW_BIAS  = 8'h84;
   localparam logic [14:0] ULAW_CLIP  = 15'd32635;
   localparam logic [21:0] PCM8_ROUND = 22'd16383;
   localparam logic [15:0] PCM8_DEN   = 16'd32767;
   localparam logic [7:0]  PCM8_MID   = 8'd128;

   // magnitude of a sample already limited to -32767..32767
   function automatic logic [14:0] sample_mag(input logic signed [15:0] s);
      logic [15:0] neg;
      neg = 16'(-s);
      return s[15] ? neg[14:0] : s[14:0];
   endfunction

   // g.711 mu-law expansion
   function automatic logic signed [15:0] ulaw_expand(input logic [7:0] code);
      logic [7:0]  u;
      logic [7:0]  base;
      logic [14:0] shifted;
      logic [14:0] mag;
      u       = ~code;
      base    = {1'b0, u[3:0], 3'b000} + ULAW_BIAS;
      shifted = 15'(base) << u[6:4];
      mag     = shifted - 15'(ULAW_BIAS);
      return u[7] ? 16'(-signed'({1'b0, mag})) : {1'b0, mag};
   endfunction

   // g.711 mu-law compression
   function automatic logic [7:0] ulaw_compress(input logic signed [15:0] s);
      logic [14:0] mag;
      logic [14:0] biased;
      logic [2:0]  expo;
      logic [14:0] shifted;
      mag = sample_mag(s);
      if (mag > ULAW_CLIP) begin
         mag = ULAW_CLIP;
      end
      biased = mag + 15'(ULAW_BIAS);
      expo   = 3'd0;
      for (int i = 1; i < 8; i++) begin
         if (biased[i + 7]) begin
            expo = 3'(i);
         end
      end
      shifted = biased >> (4'(expo) + 4'd3);
      return ~{s[15], expo, shifted[3:0]};
   endfunction

   // round(s * 127 / 32767) + 128, half away from zero
   function automatic logic [7:0] pcm8_encode(input logic signed [15:0] s);
      logic [14:0] mag;
      logic [21:0] prod;
      logic [21:0] num;
      logic [6:0]  q_est;
      logic [15:0] rem;
      logic [7:0]  q;
      mag   = sample_mag(s);
      prod  = {mag, 7'b0} - 22'(mag);
      num   = prod + PCM8_ROUND;
      // floor(num / 32768) is at most one below floor(num / 32767)
      q_est = num[21:15];
      rem   = 16'(num[14:0]) + 16'(q_est);
      q     = 8'(q_est) + ((rem >= PCM8_DEN) ? 8'd1 : 8'd0);
      return s[15] ? PCM8_MID - q : PCM8_MID + q;
   endfunction

endpackage

[rtl/audio_pcm_ulaw_codec.sv]
// audio payload codec: mu-law, unsigned 8-bit and 16-bit little-endian pcm
// an accepted item is registered in the input stage, then its result in the output register
// one item per cycle unless results stall; a 16-bit encode item gives low then high byte
// a decode item that only stores a low byte, or any item in the unused mode, gives no result
// and leaves the input stage at the next edge
// reset (synchronous, active high) clears the pipeline, the held byte and selects mu-law
module audio_pcm_ulaw_codec
   import apuc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // configuration write
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_codec_mode,
   // input items
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic [7:0]         req_in_byte,
   input  logic signed [15:0] req_in_sample,
   input  logic               req_payload_start,
   // result items
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_out_is_byte,
   output logic signed [15:0] rsp_out_sample,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last
);

   // mode register
   codec_mode_type mode_ff;

   // input stage
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_phase_ff, s1_phase_in;
   item_kind_type      s1_kind_ff;
   logic [7:0]         s1_byte_ff;
   logic signed [15:0] s1_sample_ff;
   logic               s1_start_ff;

   // held low byte for 16-bit decode
   logic               held_valid_ff, held_valid_in;
   logic [7:0]         held_low_ff, held_low_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_is_byte_ff;
   logic signed [15:0] rsp_sample_ff;
   logic [7:0]         rsp_byte_ff;
   logic               rsp_last_ff;

   // combinational result of the item in the input stage
   logic [1:0]         n_res;
   logic               res_is_byte;
   logic signed [15:0] res_sample;
   logic [7:0]         res_byte;
   logic               res_last;
   logic               held_eff;
   logic signed [15:0] sat_sample;

   logic               accept;
   logic               out_free;
   logic               emit;
   logic               final_res;
   logic               retire;

   // the user must write the register only while idle; not enforced, every write is taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ULAW;
      end else if (csr_valid) begin
         mode_ff <= codec_mode_type'(csr_codec_mode);
      end
   end

   // payload start drops a dangling half word before this byte is used
   assign held_eff   = held_valid_ff && !s1_start_ff;
   // most negative sample saturates to -32767
   assign sat_sample = (s1_sample_ff == 16'sh8000) ? 16'sh8001 : s1_sample_ff;

   always_comb begin
      n_res       = 2'd0;
      res_is_byte = (s1_kind_ff == KIND_ENCODE);
      res_sample  = '0;
      res_byte    = '0;
      res_last    = 1'b1;
      if (s1_kind_ff == KIND_DECODE) begin
         unique case (mode_ff)
            MODE_ULAW: begin
               n_res      = 2'd1;
               res_sample = ulaw_expand(s1_byte_ff);
            end
            MODE_PCM8: begin
               n_res      = 2'd1;
               res_sample = {~s1_byte_ff[7], s1_byte_ff[6:0], 8'h00};
            end
            MODE_PCM16: begin
               // first byte of a pair is only stored
               if (held_eff) begin
                  n_res      = 2'd1;
                  res_sample = {s1_byte_ff, held_low_ff};
               end
            end
            default: begin
               n_res = 2'd0;
            end
         endcase
      end else begin
         unique case (mode_ff)
            MODE_ULAW: begin
               n_res    = 2'd1;
               res_byte = ulaw_compress(sat_sample);
            end
            MODE_PCM8: begin
               n_res    = 2'd1;
               res_byte = pcm8_encode(sat_sample);
            end
            MODE_PCM16: begin
               // low byte first, high byte on the second pass
               n_res    = 2'd2;
               res_byte = s1_phase_ff ? sat_sample[15:8] : sat_sample[7:0];
               res_last = s1_phase_ff;
            end
            default: begin
               n_res = 2'd0;
            end
         endcase
      end
   end

   // handshake and sequencing
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = s1_valid_ff && (n_res != 2'd0) && out_free;
   assign final_res = (n_res != 2'd2) || s1_phase_ff;
   assign retire    = s1_valid_ff && ((n_res == 2'd0) || (out_free && final_res));
   assign req_ready = !s1_valid_ff || retire;
   assign accept    = req_valid && req_ready;

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_phase_in   = s1_phase_ff;
      held_valid_in = held_valid_ff;
      held_low_in   = held_low_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (retire) begin
         s1_valid_in = 1'b0;
         s1_phase_in = 1'b0;
      end else if (emit) begin
         // first byte of a pair has gone out
         s1_phase_in = 1'b1;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end

      // held byte changes only when a decode item leaves the input stage
      if (retire && (s1_kind_ff == KIND_DECODE)) begin
         held_valid_in = held_eff;
         if (mode_ff == MODE_PCM16) begin
            if (held_eff) begin
               held_valid_in = 1'b0;
            end else begin
               held_valid_in = 1'b1;
               held_low_in   = s1_byte_ff;
            end
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s1_phase_ff   <= 1'b0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         s1_phase_ff   <= s1_phase_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      held_low_ff <= held_low_in;
      if (accept) begin
         s1_kind_ff   <= item_kind_type'(req_kind);
         s1_byte_ff   <= req_in_byte;
         s1_sample_ff <= req_in_sample;
         s1_start_ff  <= req_payload_start;
      end
      if (emit) begin
         rsp_is_byte_ff <= res_is_byte;
         rsp_sample_ff  <= res_sample;
         rsp_byte_ff    <= res_byte;
         rsp_last_ff    <= res_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_is_byte = rsp_is_byte_ff;
   assign rsp_out_sample  = rsp_sample_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

[rtl/apuc_checker.sv]
// port-level checks for the audio codec, bound to the top level
module apuc_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_out_is_byte,
   input logic signed [15:0] rsp_out_sample,
   input logic [7:0]         rsp_out_byte,
   input logic               rsp_last
);

   // no result straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_is_byte)
         && $stable(rsp_out_sample) && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("stalled result changed");

   // a decoded sample is always the only result of its item
   a_sample_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_is_byte |-> rsp_last && rsp_out_byte == 8'd0)
      else $error("sample result malformed");

   // an encoded byte carries no sample
   a_byte_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_is_byte |-> rsp_out_sample == 16'sd0)
      else $error("byte result carries a sample");

   // the high byte follows the low byte in the very next cycle
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_out_is_byte && rsp_last)
      else $error("second byte of a pair missing");

endmodule

bind audio_pcm_ulaw_codec apuc_checker u_apuc_checker (.*);
